// ===== design/pac_pkg.sv =====
// package for the pid altitude controller: widths, csr indexes and the microcode table
`default_nettype none
package pac_pkg;

   localparam int DATA_W  = 32;
   localparam int GAIN_W  = 24;
   localparam int RATE_W  = 16;
   localparam int CSR_W   = 3;
   localparam int ERR_W   = 33;
   localparam int DIFF_W  = 34;
   localparam int INTEG_W = 48;
   localparam int DERIV_W = 51;
   localparam int SRC_W   = 51;
   localparam int MAG_W   = 50;
   localparam int HALF_W  = 25;
   localparam int PMUL_W  = HALF_W + GAIN_W;
   localparam int PROD_W  = MAG_W + GAIN_W;
   localparam int TMAG_W  = 58;
   localparam int SUM_W   = 60;
   localparam int PC_W    = 5;

   // csr register indexes
   localparam logic [CSR_W-1:0] REG_GAIN_P        = 3'd0;
   localparam logic [CSR_W-1:0] REG_GAIN_I        = 3'd1;
   localparam logic [CSR_W-1:0] REG_GAIN_D        = 3'd2;
   localparam logic [CSR_W-1:0] REG_SETPOINT      = 3'd3;
   localparam logic [CSR_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
   localparam logic [CSR_W-1:0] REG_SAMPLE_RATE   = 3'd5;
   localparam logic [CSR_W-1:0] REG_DRIVE_MIN     = 3'd6;
   localparam logic [CSR_W-1:0] REG_DRIVE_MAX     = 3'd7;

   // csr reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RST        = 24'd196608;
   localparam logic [GAIN_W-1:0] GAIN_I_RST        = 24'd6554;
   localparam logic [GAIN_W-1:0] GAIN_D_RST        = 24'd131072;
   localparam logic [DATA_W-1:0] SETPOINT_RST      = 32'd655360;
   localparam logic [RATE_W-1:0] SAMPLE_PERIOD_RST = 16'd6554;
   localparam logic [RATE_W-1:0] SAMPLE_RATE_RST   = 16'd10;
   localparam logic [DATA_W-1:0] DRIVE_MIN_RST     = 32'd0;
   localparam logic [DATA_W-1:0] DRIVE_MAX_RST     = 32'd1310720;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_RSP_FULL
   } cond_type;

   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_ERR,
      SRC_DIFF,
      SRC_INTEG,
      SRC_DERIV
   } src_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI
   } mul_type;

   typedef enum logic [2:0] {
      COEF_PERIOD,
      COEF_RATE,
      COEF_GP,
      COEF_GI,
      COEF_GD
   } coef_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_INTEG,
      WR_DERIV,
      WR_SUM_SET,
      WR_SUM_ADD,
      WR_RSP
   } wr_type;

   typedef struct packed {
      cond_type         cond;
      logic [PC_W-1:0]  jump_pc;
      logic [PC_W-1:0]  next_pc;
      logic             take_req;
      src_type          src;
      mul_type          mul;
      coef_type         coef;
      wr_type           wr;
   } uword_type;

   // control store: one word per step
   function automatic uword_type ucode_fetch(input logic [PC_W-1:0] pc);
      uword_type w;
      w.cond     = COND_NONE;
      w.jump_pc  = '0;
      w.next_pc  = pc + 5'd1;
      w.take_req = 1'b0;
      w.src      = SRC_NONE;
      w.mul      = MUL_NONE;
      w.coef     = COEF_PERIOD;
      w.wr       = WR_NONE;
      case (pc)
         5'd0: begin
            w.cond     = COND_NO_REQ;
            w.jump_pc  = 5'd0;
            w.take_req = 1'b1;
         end
         5'd1:  w.src = SRC_ERR;
         5'd2: begin w.mul = MUL_LO; w.coef = COEF_PERIOD; end
         5'd3: begin w.mul = MUL_HI; w.coef = COEF_PERIOD; end
         5'd4: begin w.wr = WR_INTEG; w.src = SRC_DIFF; end
         5'd5: begin w.mul = MUL_LO; w.coef = COEF_RATE; end
         5'd6: begin w.mul = MUL_HI; w.coef = COEF_RATE; end
         5'd7: begin w.wr = WR_DERIV; w.src = SRC_ERR; end
         5'd8: begin w.mul = MUL_LO; w.coef = COEF_GP; end
         5'd9: begin w.mul = MUL_HI; w.coef = COEF_GP; end
         5'd10: begin w.wr = WR_SUM_SET; w.src = SRC_INTEG; end
         5'd11: begin w.mul = MUL_LO; w.coef = COEF_GI; end
         5'd12: begin w.mul = MUL_HI; w.coef = COEF_GI; end
         5'd13: begin w.wr = WR_SUM_ADD; w.src = SRC_DERIV; end
         5'd14: begin w.mul = MUL_LO; w.coef = COEF_GD; end
         5'd15: begin w.mul = MUL_HI; w.coef = COEF_GD; end
         5'd16: w.wr = WR_SUM_ADD;
         5'd17: begin
            w.cond    = COND_RSP_FULL;
            w.jump_pc = 5'd17;
            w.wr      = WR_RSP;
            w.next_pc = 5'd0;
         end
         default: begin
            w.cond    = COND_ALWAYS;
            w.jump_pc = 5'd0;
         end
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== design/pid_altitude_controller.sv =====
// pid altitude controller: microcoded pid step with saturating integral and drive clamp
//
// usage
//  - req channel: one word per control tick carrying req_measured (signed q16.16);
//    a word is taken when req_valid is high and req_stall is low
//  - rsp channel: one word per tick, rsp_drive (signed q16.16) and rsp_clamped,
//    taken when rsp_valid is high and rsp_stall is low
//  - csr port: csr_we writes csr_data into register csr_index;
//    write only while no tick is in flight
//  - sequencing: a taken req word runs through all steps before rsp_valid rises; no new
//    req word is taken until the sequencer returns to its idle step, as the one shared 25x24
//    multiplier is used twice for each of the five products, plus load, write and output steps
//  - the result sits in an output register, so the next req word is taken while it
//    waits; a stalled receiver holds the sequencer only at its output step
//  - reset (synchronous, active high) restores csr reset values, clears the
//    integral and the previous error, empties the output register and restarts
//    the sequencer at its idle step
`default_nettype none
module pid_altitude_controller (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [pac_pkg::DATA_W-1:0]   req_measured,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [pac_pkg::DATA_W-1:0]        rsp_drive,
   output logic                              rsp_clamped,
   input  wire logic                         csr_we,
   input  wire logic [pac_pkg::CSR_W-1:0]    csr_index,
   input  wire logic [pac_pkg::DATA_W-1:0]   csr_data
);

   // configuration registers
   logic [pac_pkg::GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [pac_pkg::DATA_W-1:0] setpoint_ff, drive_min_ff, drive_max_ff;
   logic [pac_pkg::RATE_W-1:0] period_ff, rate_ff;

   // sequencer
   logic [pac_pkg::PC_W-1:0] pc_ff, pc_in;
   pac_pkg::uword_type       uw;
   logic                     jump;
   logic                     act;

   // datapath
   logic signed [pac_pkg::ERR_W-1:0]   err_ff, err_in, last_err_ff, last_err_in;
   logic signed [pac_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic signed [pac_pkg::DERIV_W-1:0] deriv_ff, deriv_in;
   logic signed [pac_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [pac_pkg::MAG_W-1:0]          mag_ff, mag_in;
   logic                               neg_ff, neg_in;
   logic [pac_pkg::PROD_W-1:0]         prod_ff, prod_in;

   logic signed [pac_pkg::DIFF_W-1:0]  diff;
   logic [pac_pkg::SRC_W-1:0]          src_val, src_neg;
   logic [pac_pkg::GAIN_W-1:0]         coef_val;
   logic [pac_pkg::HALF_W-1:0]         mul_a;
   logic [pac_pkg::PMUL_W-1:0]         mul_p;
   logic [pac_pkg::TMAG_W-1:0]         tmag;
   logic signed [pac_pkg::SUM_W-1:0]   term, integ_sum, min_x, max_x;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pac_pkg::DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                        rsp_clamped_ff, rsp_clamped_in;

   assign uw = pac_pkg::ucode_fetch(pc_ff);

   // conditional jump: wait steps branch to themselves and do nothing
   always_comb begin
      case (uw.cond)
         pac_pkg::COND_NONE:     jump = 1'b0;
         pac_pkg::COND_ALWAYS:   jump = 1'b1;
         pac_pkg::COND_NO_REQ:   jump = !req_valid;
         pac_pkg::COND_RSP_FULL: jump = rsp_valid_ff && rsp_stall;
         default:                jump = 1'b1;
      endcase
   end

   assign act       = !jump;
   assign pc_in     = jump ? uw.jump_pc : uw.next_pc;
   assign req_stall = !uw.take_req;

   // operand source and magnitude for the shared multiplier
   assign diff = {err_ff[pac_pkg::ERR_W-1], err_ff}
               - {last_err_ff[pac_pkg::ERR_W-1], last_err_ff};

   always_comb begin
      case (uw.src)
         pac_pkg::SRC_ERR:
            src_val = {{(pac_pkg::SRC_W-pac_pkg::ERR_W){err_ff[pac_pkg::ERR_W-1]}}, err_ff};
         pac_pkg::SRC_DIFF:
            src_val = {{(pac_pkg::SRC_W-pac_pkg::DIFF_W){diff[pac_pkg::DIFF_W-1]}}, diff};
         pac_pkg::SRC_INTEG:
            src_val = {{(pac_pkg::SRC_W-pac_pkg::INTEG_W){integ_ff[pac_pkg::INTEG_W-1]}},
                       integ_ff};
         pac_pkg::SRC_DERIV:
            src_val = deriv_ff;
         default:
            src_val = '0;
      endcase
   end

   assign src_neg = -src_val;

   always_comb begin
      case (uw.coef)
         pac_pkg::COEF_PERIOD: coef_val = {8'd0, period_ff};
         pac_pkg::COEF_RATE:   coef_val = {8'd0, rate_ff};
         pac_pkg::COEF_GP:     coef_val = gain_p_ff;
         pac_pkg::COEF_GI:     coef_val = gain_i_ff;
         pac_pkg::COEF_GD:     coef_val = gain_d_ff;
         default:              coef_val = '0;
      endcase
   end

   // 25x24 unsigned multiplier, low half of the magnitude first then high half
   assign mul_a = (uw.mul == pac_pkg::MUL_HI) ? mag_ff[pac_pkg::MAG_W-1:pac_pkg::HALF_W]
                                              : mag_ff[pac_pkg::HALF_W-1:0];
   assign mul_p = {{pac_pkg::GAIN_W{1'b0}}, mul_a} * {{pac_pkg::HALF_W{1'b0}}, coef_val};

   // signed term: q16 products drop 16 fraction bits, the derivative is exact
   assign tmag = (uw.wr == pac_pkg::WR_DERIV) ? prod_ff[pac_pkg::TMAG_W-1:0]
                                              : prod_ff[pac_pkg::PROD_W-1:16];
   assign term = neg_ff ? -{2'b00, tmag} : {2'b00, tmag};

   assign integ_sum = {{(pac_pkg::SUM_W-pac_pkg::INTEG_W){integ_ff[pac_pkg::INTEG_W-1]}},
                       integ_ff} + term;

   assign min_x = {{(pac_pkg::SUM_W-pac_pkg::DATA_W){drive_min_ff[pac_pkg::DATA_W-1]}},
                   drive_min_ff};
   assign max_x = {{(pac_pkg::SUM_W-pac_pkg::DATA_W){drive_max_ff[pac_pkg::DATA_W-1]}},
                   drive_max_ff};

   always_comb begin
      err_in         = err_ff;
      last_err_in    = last_err_ff;
      integ_in       = integ_ff;
      deriv_in       = deriv_ff;
      sum_in         = sum_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      prod_in        = prod_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      // accept: error is exact in 33 bits
      if (act && uw.take_req) begin
         err_in = {setpoint_ff[pac_pkg::DATA_W-1], setpoint_ff}
                - {req_measured[pac_pkg::DATA_W-1], req_measured};
      end

      if (act && uw.src != pac_pkg::SRC_NONE) begin
         neg_in = src_val[pac_pkg::SRC_W-1];
         mag_in = neg_in ? src_neg[pac_pkg::MAG_W-1:0] : src_val[pac_pkg::MAG_W-1:0];
      end

      case (uw.mul)
         pac_pkg::MUL_LO: prod_in = {{(pac_pkg::PROD_W-pac_pkg::PMUL_W){1'b0}}, mul_p};
         pac_pkg::MUL_HI: prod_in = prod_ff + {mul_p, {pac_pkg::HALF_W{1'b0}}};
         default:         prod_in = prod_ff;
      endcase

      if (act) begin
         case (uw.wr)
            pac_pkg::WR_INTEG: begin
               // saturate to signed 48 bits
               if (integ_sum[pac_pkg::SUM_W-1] && !(&integ_sum[pac_pkg::SUM_W-2:47])) begin
                  integ_in = {1'b1, {(pac_pkg::INTEG_W-1){1'b0}}};
               end else if (!integ_sum[pac_pkg::SUM_W-1] && (|integ_sum[pac_pkg::SUM_W-2:47])) begin
                  integ_in = {1'b0, {(pac_pkg::INTEG_W-1){1'b1}}};
               end else begin
                  integ_in = integ_sum[pac_pkg::INTEG_W-1:0];
               end
            end
            pac_pkg::WR_DERIV: begin
               deriv_in    = term[pac_pkg::DERIV_W-1:0];
               last_err_in = err_ff;
            end
            pac_pkg::WR_SUM_SET: sum_in = term;
            pac_pkg::WR_SUM_ADD: sum_in = sum_ff + term;
            pac_pkg::WR_RSP: begin
               // a raw value below the lower bound wins even with crossed bounds
               rsp_valid_in = 1'b1;
               if (sum_ff < min_x) begin
                  rsp_drive_in   = drive_min_ff;
                  rsp_clamped_in = 1'b1;
               end else if (sum_ff > max_x) begin
                  rsp_drive_in   = drive_max_ff;
                  rsp_clamped_in = 1'b1;
               end else begin
                  rsp_drive_in   = sum_ff[pac_pkg::DATA_W-1:0];
                  rsp_clamped_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // control state and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         last_err_ff  <= '0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         last_err_ff  <= last_err_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      deriv_ff       <= deriv_in;
      sum_ff         <= sum_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      prod_ff        <= prod_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   // csr write port
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= pac_pkg::GAIN_P_RST;
         gain_i_ff    <= pac_pkg::GAIN_I_RST;
         gain_d_ff    <= pac_pkg::GAIN_D_RST;
         setpoint_ff  <= pac_pkg::SETPOINT_RST;
         period_ff    <= pac_pkg::SAMPLE_PERIOD_RST;
         rate_ff      <= pac_pkg::SAMPLE_RATE_RST;
         drive_min_ff <= pac_pkg::DRIVE_MIN_RST;
         drive_max_ff <= pac_pkg::DRIVE_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            pac_pkg::REG_GAIN_P:        gain_p_ff    <= csr_data[pac_pkg::GAIN_W-1:0];
            pac_pkg::REG_GAIN_I:        gain_i_ff    <= csr_data[pac_pkg::GAIN_W-1:0];
            pac_pkg::REG_GAIN_D:        gain_d_ff    <= csr_data[pac_pkg::GAIN_W-1:0];
            pac_pkg::REG_SETPOINT:      setpoint_ff  <= csr_data;
            pac_pkg::REG_SAMPLE_PERIOD: period_ff    <= csr_data[pac_pkg::RATE_W-1:0];
            pac_pkg::REG_SAMPLE_RATE:   rate_ff      <= csr_data[pac_pkg::RATE_W-1:0];
            pac_pkg::REG_DRIVE_MIN:     drive_min_ff <= csr_data;
            pac_pkg::REG_DRIVE_MAX:     drive_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

endmodule
`default_nettype wire

// ===== design/pac_checker.sv =====
// port-level checks for the pid altitude controller, bound to the top level
`default_nettype none
module pac_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [pac_pkg::DATA_W-1:0]  rsp_drive,
   input wire logic                        rsp_clamped
);

   // one tick in flight: after taking a word the block is busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("req word taken twice in a row");

   // a result appears only from the output step, where req is stalled
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("rsp word appeared while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_drive) && $stable(rsp_clamped)))
      else $error("rsp payload changed while stalled");

endmodule

bind pid_altitude_controller pac_checker u_pac_checker (.*);
`default_nettype wire
